@@ rtl/pvcm_pkg.sv @@
package pvcm_pkg;

  localparam int WORD_W = 32;

  localparam logic [1:0] MODE_A    = 2'd0;
  localparam logic [1:0] MODE_B    = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  typedef enum logic [1:0] {
    SRC_A    = 2'd0,
    SRC_B    = 2'd1,
    SRC_LAST = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_TICK   = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] linear_x;
    logic [WORD_W-1:0] linear_y;
    logic [WORD_W-1:0] linear_z;
    logic [WORD_W-1:0] angular_x;
    logic [WORD_W-1:0] angular_y;
    logic [WORD_W-1:0] angular_z;
  } cmd_t;

  typedef struct packed {
    op_kind_t kind;
    cmd_t     cmd;
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_LOAD = 1'b1
  } back_state_t;

endpackage

@@ rtl/pvcm_front.sv @@
module pvcm_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [31:0]       in_linear_x,
  input  logic [31:0]       in_linear_y,
  input  logic [31:0]       in_linear_z,
  input  logic [31:0]       in_angular_x,
  input  logic [31:0]       in_angular_y,
  input  logic [31:0]       in_angular_z,
  output logic              op_push,
  output pvcm_pkg::op_t     op,
  input  logic              op_full
);
  import pvcm_pkg::*;

  logic known_mode;

  assign in_stall = op_full;

  always_comb begin
    known_mode       = 1'b1;
    op.kind          = OP_TICK;
    op.cmd.linear_x  = in_linear_x;
    op.cmd.linear_y  = in_linear_y;
    op.cmd.linear_z  = in_linear_z;
    op.cmd.angular_x = in_angular_x;
    op.cmd.angular_y = in_angular_y;
    op.cmd.angular_z = in_angular_z;
    case (in_mode)
      MODE_A:    op.kind = OP_PUSH_A;
      MODE_B:    op.kind = OP_PUSH_B;
      MODE_TICK: op.kind = OP_TICK;
      default:   known_mode = 1'b0;
    endcase
  end

  // undefined mode is taken and dropped
  assign op_push = in_valid & ~op_full & known_mode;

endmodule

@@ rtl/pvcm_opq.sv @@
module pvcm_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pvcm_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          op_valid,
  output pvcm_pkg::op_t op
);
  import pvcm_pkg::*;

  op_t        ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = ent_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & op_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ rtl/pvcm_cmdq.sv @@
module pvcm_cmdq #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pvcm_pkg::qctl_t  ctl,
  input  pvcm_pkg::cmd_t   wr_cmd,
  output pvcm_pkg::cmd_t   rd_cmd,
  output pvcm_pkg::qstat_t stat
);
  import pvcm_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 2;

  cmd_t          mem [QUEUE_DEPTH];
  cmd_t          rd_cmd_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic          do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign do_push    = ctl.push & ~stat.full;
  assign do_pop     = ctl.pop & ~stat.empty;
  assign rd_cmd     = rd_cmd_r;

  assign tail_sum = SW'(head_r) + SW'(cnt_r);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : AW'(tail_sum);

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      cnt_nxt  = cnt_r - CW'(1);
    end
    if (ctl.flush) begin
      head_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wr_cmd;
    end
    if (do_pop) begin
      rd_cmd_r <= mem[head_r];
    end
  end

endmodule

@@ rtl/pvcm_back.sv @@
module pvcm_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           a_buffered,
  input  logic           b_buffered,
  input  logic           op_valid,
  input  pvcm_pkg::op_t  op,
  output logic           op_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_source,
  output pvcm_pkg::cmd_t out_cmd
);
  import pvcm_pkg::*;

  back_state_t state_r, state_nxt;
  src_t        src_r, src_nxt;
  cmd_t        last_b_r, last_b_nxt;
  logic        last_b_valid_r, last_b_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  src_t        out_src_r, out_src_nxt;
  cmd_t        out_cmd_r, out_cmd_nxt;
  logic        out_free;

  qctl_t  a_ctl, b_ctl;
  qstat_t a_stat, b_stat;
  cmd_t   a_rd, b_rd;

  pvcm_cmdq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_a_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (a_ctl),
    .wr_cmd (op.cmd),
    .rd_cmd (a_rd),
    .stat   (a_stat)
  );

  pvcm_cmdq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_b_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (b_ctl),
    .wr_cmd (op.cmd),
    .rd_cmd (b_rd),
    .stat   (b_stat)
  );

  // output register is free next cycle
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (op_valid && op.kind == OP_TICK && out_free &&
            (!a_stat.empty || !b_stat.empty)) begin
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    op_pop           = 1'b0;
    a_ctl            = '0;
    b_ctl            = '0;
    src_nxt          = src_r;
    last_b_nxt       = last_b_r;
    last_b_valid_nxt = last_b_valid_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_src_nxt      = out_src_r;
    out_cmd_nxt      = out_cmd_r;
    case (state_r)
      BK_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            OP_PUSH_A: begin
              op_pop     = 1'b1;
              a_ctl.push = 1'b1;
            end
            OP_PUSH_B: begin
              op_pop           = 1'b1;
              b_ctl.push       = 1'b1;
              last_b_nxt       = op.cmd;
              last_b_valid_nxt = 1'b1;
            end
            OP_TICK: begin
              if (out_free) begin
                op_pop = 1'b1;
                if (!a_stat.empty) begin
                  a_ctl.pop   = 1'b1;
                  a_ctl.flush = ~a_buffered;
                  b_ctl.pop   = 1'b1;
                  src_nxt     = SRC_A;
                end else if (!b_stat.empty) begin
                  b_ctl.pop   = 1'b1;
                  b_ctl.flush = ~b_buffered;
                  src_nxt     = SRC_B;
                end else if (last_b_valid_r) begin
                  last_b_valid_nxt = 1'b0;
                  out_valid_nxt    = 1'b1;
                  out_src_nxt      = SRC_LAST;
                  out_cmd_nxt      = last_b_r;
                end
              end
            end
            default: op_pop = 1'b1;
          endcase
        end
      end
      BK_LOAD: begin
        out_valid_nxt = 1'b1;
        out_src_nxt   = src_r;
        out_cmd_nxt   = (src_r == SRC_A) ? a_rd : b_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= BK_IDLE;
      last_b_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      last_b_valid_r <= last_b_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    last_b_r  <= last_b_nxt;
    out_src_r <= out_src_nxt;
    out_cmd_r <= out_cmd_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_source = out_src_r;
  assign out_cmd    = out_cmd_r;

endmodule

@@ rtl/priority_velocity_command_mux_unit.sv @@
// Priority mux for six-word velocity commands from sources A and B, each with
// its own command queue of QUEUE_DEPTH entries; a tick publishes the oldest A
// command (dropping one waiting B command), else the oldest B command, else
// the last B command once. Accepted beats pass through a two-entry op queue
// to the back end; a tick that publishes a queued command passes through the
// load state as well (the queue memory read is registered), unlike a beat or a
// tick served from the last B command or with nothing to send.
// A tick waits in the op queue while a published beat is stalled on the
// output. Mode 3 beats are accepted and dropped. Config bit 0 of each
// register selects buffered (1) or flush-after-serve (0); write only when idle.
module priority_velocity_command_mux_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_linear_x,
  input  logic [31:0] in_linear_y,
  input  logic [31:0] in_linear_z,
  input  logic [31:0] in_angular_x,
  input  logic [31:0] in_angular_y,
  input  logic [31:0] in_angular_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_source,
  output logic [31:0] out_linear_x,
  output logic [31:0] out_linear_y,
  output logic [31:0] out_linear_z,
  output logic [31:0] out_angular_x,
  output logic [31:0] out_angular_y,
  output logic [31:0] out_angular_z,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pvcm_pkg::*;

  localparam logic REG_A_BUFFERED = 1'b0;
  localparam logic REG_B_BUFFERED = 1'b1;

  logic a_buf_r, a_buf_nxt;
  logic b_buf_r, b_buf_nxt;
  logic cfg_wr;

  logic front_push, opq_full, opq_valid, opq_pop;
  op_t  front_op, opq_op;
  cmd_t out_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    a_buf_nxt = a_buf_r;
    b_buf_nxt = b_buf_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_A_BUFFERED: a_buf_nxt = pwdata[0];
        REG_B_BUFFERED: b_buf_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_buf_r <= 1'b0;
      b_buf_r <= 1'b1;
    end else begin
      a_buf_r <= a_buf_nxt;
      b_buf_r <= b_buf_nxt;
    end
  end

  assign prdata = {31'd0, (paddr[2] == REG_B_BUFFERED) ? b_buf_r : a_buf_r};

  pvcm_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_linear_x  (in_linear_x),
    .in_linear_y  (in_linear_y),
    .in_linear_z  (in_linear_z),
    .in_angular_x (in_angular_x),
    .in_angular_y (in_angular_y),
    .in_angular_z (in_angular_z),
    .op_push      (front_push),
    .op           (front_op),
    .op_full      (opq_full)
  );

  pvcm_opq u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_op  (front_op),
    .full     (opq_full),
    .pop      (opq_pop),
    .op_valid (opq_valid),
    .op       (opq_op)
  );

  pvcm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .a_buffered (a_buf_r),
    .b_buffered (b_buf_r),
    .op_valid   (opq_valid),
    .op         (opq_op),
    .op_pop     (opq_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_source (out_source),
    .out_cmd    (out_cmd)
  );

  assign out_linear_x  = out_cmd.linear_x;
  assign out_linear_y  = out_cmd.linear_y;
  assign out_linear_z  = out_cmd.linear_z;
  assign out_angular_x = out_cmd.angular_x;
  assign out_angular_y = out_cmd.angular_y;
  assign out_angular_z = out_cmd.angular_z;

endmodule
